>>> rtl/mlpn_pkg.sv
// mlpn_pkg: shared types and constants for the multilinear polynomial neuron evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlpn_pkg;

    localparam int MLPN_MAX_INPUTS  = 4;
    localparam int MLPN_VALUE_FIELDS = 4;
    localparam int MLPN_NUM_W       = 51;
    localparam int MLPN_ACT_RESET   = 4;
    localparam logic [15:0] MLPN_DIV_ONE = 16'h8000;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_EVAL   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_ZDIV  = 2'd3;

    typedef struct packed {
        logic capture;
        logic wr;
        logic rd_idx;
        logic rd_bias;
        logic rd_mask;
        logic take_rd;
        logic take_bias;
        logic j_inc;
        logic x_mul;
        logic x_rnd;
        logic zdiv_set;
        logic t_mul;
        logic d_init;
        logic d_step;
        logic d_fin;
        logic acc_add;
        logic mask_inc;
        logic set_oob;
        logic set_zwr;
        logic eval_done;
        logic out_load;
    } mlpn_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       oob;
        logic       div_in_zero;
        logic       n_zero;
        logic       j_done;
        logic       bit_set;
        logic       ent_div_zero;
        logic       d_last;
        logic       mask_last;
        logic       out_free;
    } mlpn_stat_t;

endpackage
`default_nettype wire

>>> rtl/mlpn_ram.sv
// mlpn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mlpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/mlpn_ctrl.sv
// mlpn_ctrl: request sequencer for the evaluator.
// Depends on mlpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlpn_ctrl
    import mlpn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire mlpn_stat_t stat,
    output mlpn_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RDW, S_BIAS, S_TSTART, S_SCAN, S_XMUL, S_XRND,
        S_TMUL, S_DINIT, S_DSTEP, S_DFIN, S_ACC, S_NEXT, S_FIN
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                case (stat.req)
                    REQ_WRITE:
                    begin
                        if (stat.oob)
                            cmd.set_oob = 1'b1;
                        else if (stat.div_in_zero)
                            cmd.set_zwr = 1'b1;
                        else
                            cmd.wr = 1'b1;
                    end
                    REQ_READ:
                    begin
                        if (stat.oob)
                            cmd.set_oob = 1'b1;
                        else
                        begin
                            cmd.rd_idx = 1'b1;
                            state_next = S_RDW;
                        end
                    end
                    REQ_EVAL:
                    begin
                        cmd.rd_bias = 1'b1;
                        state_next  = S_BIAS;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RDW:
            begin
                cmd.take_rd = 1'b1;
                state_next  = S_FIN;
            end
            S_BIAS:
            begin
                cmd.take_bias = 1'b1;
                if (stat.n_zero)
                begin
                    cmd.eval_done = 1'b1;
                    state_next    = S_FIN;
                end
                else
                    state_next = S_TSTART;
            end
            S_TSTART:
            begin
                cmd.rd_mask = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.j_done)
                    state_next = S_TMUL;
                else if (stat.bit_set)
                    state_next = S_XMUL;
                else
                    cmd.j_inc = 1'b1;
            end
            S_XMUL:
            begin
                cmd.x_mul  = 1'b1;
                state_next = S_XRND;
            end
            S_XRND:
            begin
                cmd.x_rnd  = 1'b1;
                cmd.j_inc  = 1'b1;
                state_next = S_SCAN;
            end
            S_TMUL:
            begin
                if (stat.ent_div_zero)
                begin
                    cmd.zdiv_set = 1'b1;
                    state_next   = S_NEXT;
                end
                else
                begin
                    cmd.t_mul  = 1'b1;
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.d_init = 1'b1;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.d_step = 1'b1;
                if (stat.d_last)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                cmd.d_fin  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                if (stat.mask_last)
                begin
                    cmd.eval_done = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.mask_inc = 1'b1;
                    state_next   = S_TSTART;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> rtl/mlpn_dp.sv
// mlpn_dp: coefficient table, multiplier, rounding, serial divider and accumulator.
// Depends on mlpn_pkg and mlpn_ram.
`timescale 1ns / 1ps
`default_nettype none
module mlpn_dp
    import mlpn_pkg::*;
#(
    parameter int MAX_INPUTS = MLPN_MAX_INPUTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mlpn_cmd_t          cmd,
    output mlpn_stat_t              stat,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_data,
    input  wire logic [1:0]         req_type,
    input  wire logic [3:0]         coeff_index,
    input  wire logic signed [15:0] coeff_mul,
    input  wire logic [15:0]        coeff_div,
    input  wire logic signed [15:0] in_value_a,
    input  wire logic signed [15:0] in_value_b,
    input  wire logic signed [15:0] in_value_c,
    input  wire logic signed [15:0] in_value_d,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic signed [31:0]      result_value,
    output logic [1:0]              status
);

    localparam int DEPTH = 1 << MAX_INPUTS;
    localparam int AW    = MAX_INPUTS;
    localparam int MW    = (MAX_INPUTS < MLPN_VALUE_FIELDS) ? MAX_INPUTS : MLPN_VALUE_FIELDS;
    localparam int NW    = MLPN_NUM_W;
    localparam int CW    = $clog2(NW);

    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [NW-1:0] q,
                                                   output logic sat);
        logic signed [31:0] r;
        sat = 1'b0;
        if (!neg && q > NW'(32'h7FFF_FFFF))
        begin
            sat = 1'b1;
            r   = 32'sh7FFF_FFFF;
        end
        else if (neg && q > NW'(32'h8000_0000))
        begin
            sat = 1'b1;
            r   = 32'sh8000_0000;
        end
        else
            r = neg ? -q[31:0] : q[31:0];
        return r;
    endfunction

    logic [2:0]         act_reg;
    logic [1:0]         req_reg;
    logic [3:0]         idx_reg;
    logic [15:0]        mul_reg, div_reg;
    logic signed [15:0] x_reg [MLPN_VALUE_FIELDS];
    logic [2:0]         n_eff;
    logic [MW:0]        cnt_full;
    logic [MW-1:0]      mask_reg;
    logic [2:0]         j_reg;
    logic [MW-1:0]      mask_sh;
    logic signed [31:0] prod_reg, term_reg, acc_reg, result_reg;
    logic signed [47:0] p_reg;
    logic [1:0]         status_reg;
    logic               sat_reg, zdiv_reg, neg_reg;
    logic [NW-1:0]      quo_reg;
    logic [16:0]        rem_reg;
    logic [CW-1:0]      dcnt_reg;
    logic [DEPTH-1:0]   vld_reg;
    logic               vld_rd_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_val_reg;
    logic [1:0]         out_st_reg;

    logic               ram_wr, ram_rd;
    logic [AW-1:0]      ram_rd_addr;
    logic [31:0]        ram_rd_data;
    logic signed [15:0] ent_mul;
    logic [15:0]        ent_div;
    logic [47:0]        p_mag;
    logic [NW-1:0]      rnd_q;
    logic [16:0]        rem_sh;
    logic signed [32:0] sum;
    logic signed [31:0] rnd_val, fin_val;
    logic               rnd_sat, fin_sat;

    assign n_eff    = (act_reg > 3'(MW)) ? 3'(MW) : act_reg;
    assign cnt_full = (MW+1)'(1) << n_eff;
    assign mask_sh  = mask_reg >> j_reg;

    assign ram_wr      = cmd.wr;
    assign ram_rd      = cmd.rd_idx | cmd.rd_bias | cmd.rd_mask;
    assign ram_rd_addr = cmd.rd_idx ? AW'(idx_reg) : (cmd.rd_mask ? AW'(mask_reg) : '0);

    mlpn_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_tab (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (AW'(idx_reg)),
        .wr_data ({mul_reg, div_reg}),
        .rd_en   (ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ent_mul = vld_rd_reg ? ram_rd_data[31:16] : 16'sd0;
    assign ent_div = vld_rd_reg ? ram_rd_data[15:0] : MLPN_DIV_ONE;

    assign p_mag   = p_reg[47] ? 48'(-p_reg) : 48'(p_reg);
    assign rnd_q   = NW'((p_mag + 48'd2048) >> 12);
    assign rem_sh  = {rem_reg[15:0], quo_reg[NW-1]};
    assign sum     = 33'(acc_reg) + 33'(term_reg);

    always_comb
    begin
        rnd_val = sat_mag(p_reg[47], rnd_q, rnd_sat);
        fin_val = sat_mag(neg_reg, quo_reg, fin_sat);
    end

    always_comb
    begin
        stat.req          = req_reg;
        stat.oob          = (idx_reg >> n_eff) != 4'd0;
        stat.div_in_zero  = (div_reg == 16'd0);
        stat.n_zero       = (n_eff == 3'd0);
        stat.j_done       = (j_reg == n_eff);
        stat.bit_set      = mask_sh[0];
        stat.ent_div_zero = (ent_div == 16'd0);
        stat.d_last       = (dcnt_reg == CW'(NW-1));
        stat.mask_last    = (mask_reg == cnt_full[MW-1:0] - 1'b1);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 3'(MLPN_ACT_RESET);
            vld_reg       <= '0;
            vld_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            sat_reg       <= 1'b0;
            zdiv_reg      <= 1'b0;
            req_reg       <= '0;
            idx_reg       <= '0;
            div_reg       <= '0;
            mask_reg      <= '0;
            j_reg         <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
                act_reg <= cfg_data;
            if (cmd.wr)
                vld_reg[AW'(idx_reg)] <= 1'b1;
            if (ram_rd)
                vld_rd_reg <= vld_reg[ram_rd_addr];
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.capture)
            begin
                req_reg    <= req_type;
                idx_reg    <= coeff_index;
                div_reg    <= coeff_div;
                status_reg <= ST_OK;
                sat_reg    <= 1'b0;
                zdiv_reg   <= 1'b0;
            end
            if (cmd.set_oob)
                status_reg <= ST_INDEX;
            if (cmd.set_zwr)
                status_reg <= ST_ZDIV;
            if (cmd.eval_done)
                status_reg <= zdiv_reg ? ST_ZDIV : (sat_reg ? ST_SAT : ST_OK);
            if (cmd.take_bias)
                mask_reg <= MW'(1);
            else if (cmd.mask_inc)
                mask_reg <= mask_reg + 1'b1;
            if (cmd.rd_mask)
                j_reg <= '0;
            else if (cmd.j_inc)
                j_reg <= j_reg + 1'b1;
            if (cmd.x_rnd && rnd_sat)
                sat_reg <= 1'b1;
            if (cmd.d_fin && fin_sat)
                sat_reg <= 1'b1;
            if (cmd.acc_add && (sum[32] != sum[31]))
                sat_reg <= 1'b1;
            if (cmd.zdiv_set)
                zdiv_reg <= 1'b1;
            if (cmd.d_init)
                dcnt_reg <= '0;
            else if (cmd.d_step)
                dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mul_reg    <= coeff_mul;
            x_reg[0]   <= in_value_a;
            x_reg[1]   <= in_value_b;
            x_reg[2]   <= in_value_c;
            x_reg[3]   <= in_value_d;
            result_reg <= '0;
        end
        if (cmd.take_rd)
            result_reg <= 32'(ent_mul);
        if (cmd.eval_done)
            result_reg <= (cmd.take_bias) ? 32'(ent_mul) : acc_reg;
        if (cmd.take_bias)
            acc_reg <= 32'(ent_mul);
        if (cmd.rd_mask)
            prod_reg <= 32'sd4096;
        if (cmd.x_mul)
            p_reg <= prod_reg * x_reg[j_reg[1:0]];
        if (cmd.t_mul)
            p_reg <= prod_reg * ent_mul;
        if (cmd.x_rnd)
            prod_reg <= rnd_val;
        if (cmd.d_init)
        begin
            neg_reg <= p_reg[47];
            quo_reg <= (NW'(p_mag) << 3) + NW'(ent_div[15:1]);
            rem_reg <= '0;
        end
        if (cmd.d_step)
        begin
            if (rem_sh >= {1'b0, ent_div})
            begin
                rem_reg <= rem_sh - {1'b0, ent_div};
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.d_fin)
            term_reg <= fin_val;
        if (cmd.acc_add)
        begin
            if (sum[32] != sum[31])
                acc_reg <= sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                acc_reg <= sum[31:0];
        end
        if (cmd.out_load)
        begin
            out_val_reg <= result_reg;
            out_st_reg  <= status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign status       = out_st_reg;

endmodule
`default_nettype wire

>>> rtl/multilinear_poly_neuron_eval_unit.sv
// Evaluation with n active inputs runs over the 2^n - 1 subset terms; each term uses
// the 32x16 multiplier and a 51-step serial divider that gives one quotient bit per cycle.
// One request in flight; the next is taken once the result sits in the output register.
// Reset: asynchronous active low; table reads as multiplier 0, divisor 1.0, inputs 4.
`timescale 1ns / 1ps
`default_nettype none
module multilinear_poly_neuron_eval_unit
    import mlpn_pkg::*;
#(
    parameter int MAX_INPUTS = MLPN_MAX_INPUTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [3:0]         coeff_index,
    input  wire logic signed [15:0] coeff_mul,
    input  wire logic [15:0]        coeff_div,
    input  wire logic signed [15:0] in_value_a,
    input  wire logic signed [15:0] in_value_b,
    input  wire logic signed [15:0] in_value_c,
    input  wire logic signed [15:0] in_value_d,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      result_value,
    output logic [1:0]              status
);

    mlpn_cmd_t  cmd;
    mlpn_stat_t stat;

    assign cfg_ready = 1'b1;

    mlpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlpn_dp #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .coeff_index  (coeff_index),
        .coeff_mul    (coeff_mul),
        .coeff_div    (coeff_div),
        .in_value_a   (in_value_a),
        .in_value_b   (in_value_b),
        .in_value_c   (in_value_c),
        .in_value_d   (in_value_d),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .status       (status)
    );

endmodule
`default_nettype wire
